/* rtl/mild_pkg.sv */
// ----------------------------------------------------------------------------
// mild_pkg
// Shared types and constants for the Morse interval letter decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mild_pkg;

   localparam int SYMBOLS_PER_LETTER = 4;
   localparam int COUNT_WIDTH        = $clog2(SYMBOLS_PER_LETTER);
   localparam int INTERVAL_WIDTH     = 16;
   localparam int LETTER_WIDTH       = 7;
   localparam int CSR_INDEX_WIDTH    = 2;

   localparam logic [INTERVAL_WIDTH-1:0] DASH_THRESHOLD_RESET       = 16'd4500;
   localparam logic [INTERVAL_WIDTH-1:0] SPACE_THRESHOLD_RESET      = 16'd18000;
   localparam logic [INTERVAL_WIDTH-1:0] LETTER_GAP_THRESHOLD_RESET = 16'd28000;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DASH_THRESHOLD       = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPACE_THRESHOLD      = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LETTER_GAP_THRESHOLD = 2'd2;

   localparam logic [LETTER_WIDTH-1:0] LETTER_FIRST = 7'h61;
   localparam logic [LETTER_WIDTH-1:0] LETTER_LAST  = 7'h7a;

   typedef enum logic [1:0] {
      SYM_DOT   = 2'd0,
      SYM_DASH  = 2'd1,
      SYM_SPACE = 2'd2
   } sym_type;

   typedef struct packed {
      logic [INTERVAL_WIDTH-1:0] dash;
      logic [INTERVAL_WIDTH-1:0] space;
      logic [INTERVAL_WIDTH-1:0] gap;
   } mild_thresh_type;

endpackage

`default_nettype wire

/* rtl/mild_symbol_stage.sv */
// ----------------------------------------------------------------------------
// mild_symbol_stage
// Classifies one interval, keeps the symbol buffer and looks up the letter.
// ----------------------------------------------------------------------------
`default_nettype none

module mild_symbol_stage import mild_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [INTERVAL_WIDTH-1:0] interval,
   input  mild_thresh_type           thresh,
   output logic                      emit,
   output logic [LETTER_WIDTH-1:0]   letter
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_LAST = COUNT_WIDTH'(SYMBOLS_PER_LETTER - 1);

   sym_type                buffer_ff [SYMBOLS_PER_LETTER];
   sym_type                buffer_in [SYMBOLS_PER_LETTER];
   sym_type                code      [SYMBOLS_PER_LETTER];
   sym_type                symbol;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;

   function automatic logic [LETTER_WIDTH-1:0] lookup(
      input sym_type a, input sym_type b, input sym_type c, input sym_type d);
      logic [LETTER_WIDTH-1:0] r;
      r = LETTER_FIRST;
      if (a == SYM_DOT) begin
         if (b == SYM_DOT) begin
            if (c == SYM_DOT) begin
               if (d == SYM_DOT) r = 7'h68;
               else if (d == SYM_DASH) r = 7'h76;
               else if (d == SYM_SPACE) r = 7'h73;
            end else if (c == SYM_DASH) begin
               if (d == SYM_DOT) r = 7'h66;
               else if (d == SYM_SPACE) r = 7'h75;
            end else if (c == SYM_SPACE) begin
               r = 7'h69;
            end
         end else if (b == SYM_DASH) begin
            if (c == SYM_DOT) begin
               if (d == SYM_DOT) r = 7'h6c;
               else if (d == SYM_SPACE) r = 7'h72;
            end else if (c == SYM_DASH) begin
               if (d == SYM_DOT) r = 7'h70;
               else if (d == SYM_DASH) r = 7'h6a;
               else if (d == SYM_SPACE) r = 7'h77;
            end
         end else if (b == SYM_SPACE) begin
            r = 7'h65;
         end
      end else if (a == SYM_DASH) begin
         if (b == SYM_DOT) begin
            if (c == SYM_DOT) begin
               if (d == SYM_DOT) r = 7'h62;
               else if (d == SYM_DASH) r = 7'h78;
               else if (d == SYM_SPACE) r = 7'h64;
            end else if (c == SYM_DASH) begin
               if (d == SYM_DOT) r = 7'h63;
               else if (d == SYM_DASH) r = 7'h79;
               else if (d == SYM_SPACE) r = 7'h6b;
            end else if (c == SYM_SPACE) begin
               r = 7'h6e;
            end
         end else if (b == SYM_DASH) begin
            if (c == SYM_DOT) begin
               if (d == SYM_DOT) r = 7'h7a;
               else if (d == SYM_DASH) r = 7'h71;
               else if (d == SYM_SPACE) r = 7'h67;
            end else if (c == SYM_DASH) begin
               r = 7'h6f;
            end else if (c == SYM_SPACE) begin
               r = 7'h6d;
            end
         end else if (b == SYM_SPACE) begin
            r = 7'h74;
         end
      end
      return r;
   endfunction

   always_comb begin
      if (interval > thresh.dash && interval <= thresh.space) begin
         symbol = SYM_DASH;
      end else if (interval >= thresh.space) begin
         symbol = SYM_SPACE;
      end else begin
         symbol = SYM_DOT;
      end

      code           = buffer_ff;
      code[count_ff] = symbol;

      emit   = (interval > thresh.gap) || (count_ff == COUNT_LAST);
      letter = lookup(code[0], code[1], code[2], code[3]);

      buffer_in = buffer_ff;
      count_in  = count_ff;
      if (step) begin
         if (emit) begin
            for (int i = 0; i < SYMBOLS_PER_LETTER; i++) begin
               buffer_in[i] = SYM_SPACE;
            end
            count_in = '0;
         end else begin
            buffer_in = code;
            count_in  = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SYMBOLS_PER_LETTER; i++) begin
            buffer_ff[i] <= SYM_SPACE;
         end
         count_ff <= '0;
      end else begin
         buffer_ff <= buffer_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_emit_clears_count: assert property (@(posedge clock) disable iff (reset)
      step && emit |=> count_ff == '0)
      else $error("symbol count not cleared after letter");

   a_store_advances_count: assert property (@(posedge clock) disable iff (reset)
      step && !emit |=> count_ff == $past(count_ff) + 1'b1)
      else $error("symbol count did not advance");

   a_empty_buffer_is_space: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> buffer_ff[0] == SYM_SPACE && buffer_ff[1] == SYM_SPACE &&
                         buffer_ff[2] == SYM_SPACE && buffer_ff[3] == SYM_SPACE)
      else $error("empty symbol buffer holds a symbol");
`endif

endmodule

`default_nettype wire

/* rtl/morse_interval_letter_decoder_core.sv */
// ----------------------------------------------------------------------------
// morse_interval_letter_decoder_core
// Turns measured key intervals into lower-case ASCII letters.
//
// Each request on req_ carries one key interval in timer ticks. It is taken
// into an input register, classified as dot, dash or space and appended to
// a four-symbol buffer. A request longer than the letter gap, or the one
// that fills the buffer, produces one letter on rsp_; others produce none.
// A request is held in the input register, its letter in the result register.
// Throughput: one request per cycle unless rsp_ stalls, set by the single
// input register and single result register around classify and lookup.
// While rsp_ stalls, requests that produce no letter still drain; a request
// that produces a letter waits in the input register and req_ready drops.
// Thresholds are written on csr_ (index 0 dash, 1 space, 2 letter gap),
// always ready; write them only while the block is idle.
// Reset restores the default thresholds, empties the buffer and drops any
// request or letter in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_interval_letter_decoder_core import mild_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [INTERVAL_WIDTH-1:0]  req_interval_ticks,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [LETTER_WIDTH-1:0]    rsp_letter,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [INTERVAL_WIDTH-1:0]  csr_wdata
);

   mild_thresh_type           thresh_ff;
   mild_thresh_type           thresh_in;
   logic                      in_valid_ff;
   logic                      in_valid_in;
   logic [INTERVAL_WIDTH-1:0] in_ticks_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [LETTER_WIDTH-1:0]   rsp_letter_ff;
   logic                      emit;
   logic [LETTER_WIDTH-1:0]   letter;
   logic                      step;

   mild_symbol_stage u_stage (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .interval (in_ticks_ff),
      .thresh   (thresh_ff),
      .emit     (emit),
      .letter   (letter)
   );

   assign csr_ready  = 1'b1;
   assign step       = in_valid_ff && (!emit || !rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || step;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_letter = rsp_letter_ff;

   always_comb begin
      thresh_in = thresh_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DASH_THRESHOLD:       thresh_in.dash  = csr_wdata;
            CSR_SPACE_THRESHOLD:      thresh_in.space = csr_wdata;
            CSR_LETTER_GAP_THRESHOLD: thresh_in.gap   = csr_wdata;
            default:                  thresh_in = thresh_ff;
         endcase
      end

      in_valid_in = (req_valid && req_ready) || (in_valid_ff && !step);

      if (step && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff.dash  <= DASH_THRESHOLD_RESET;
         thresh_ff.space <= SPACE_THRESHOLD_RESET;
         thresh_ff.gap   <= LETTER_GAP_THRESHOLD_RESET;
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         thresh_ff    <= thresh_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ticks_ff <= req_interval_ticks;
      end
      if (step && emit) begin
         rsp_letter_ff <= letter;
      end
   end

`ifndef SYNTHESIS
   a_letter_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_letter_ff >= LETTER_FIRST && rsp_letter_ff <= LETTER_LAST)
      else $error("letter outside a to z");

   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && emit && rsp_valid_ff)
      else $error("request refused with nothing held");

   a_letter_lands: assert property (@(posedge clock) disable iff (reset)
      step && emit |=> rsp_valid_ff && rsp_letter_ff == $past(letter))
      else $error("letter not loaded into result register");
`endif

endmodule

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for morse_interval_letter_decoder_core.
//
// Key intervals go in on req_ and letters are checked on rsp_ against a
// behavioral decoder kept in step with every request taken. A short directed
// table covers the threshold boundaries, the buffer-full and letter-gap
// endings, spaces inside a letter and codes with no letter. Phases of random
// traffic follow, each under a new threshold setting written on csr_ while
// the block is idle: defaults, all zero, all ones, ordered and unordered
// random values, plus writes to the unused index. Most random traffic is
// whole letters with random timing; the rest is raw intervals. Both sides
// idle at random, and some phases run with no idling at all.
// ----------------------------------------------------------------------------

module tb;
   import mild_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 6;
   localparam int MAX_IDLE      = 17;
   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 140;
   localparam int MAX_TICKS     = 65535;

   typedef struct packed {
      logic [INTERVAL_WIDTH-1:0] ticks;
      byte                       ch;
   } tick_row_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [INTERVAL_WIDTH-1:0]  req_interval_ticks;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [LETTER_WIDTH-1:0]    rsp_letter;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [INTERVAL_WIDTH-1:0]  csr_wdata;

   mild_thresh_type         thr;
   sym_type                 sym_buf [SYMBOLS_PER_LETTER];
   int                      sym_count;
   logic [LETTER_WIDTH-1:0] letters_due [$];
   logic [LETTER_WIDTH-1:0] due_letter;
   int                      mismatches;
   int                      items_sent;
   int                      cycles;
   int                      rsp_wait;
   int                      rsp_hold;
   bit                      no_idle;

   tick_row_type directed_rows [0:23] = '{
      '{16'd65535, "a"},
      '{16'd0,     0  }, '{16'd65535, "e"},
      '{16'd4500,  0  }, '{16'd4501,  0  }, '{16'd18000, 0  }, '{16'd18001, "w"},
      '{16'd28000, 0  }, '{16'd28001, "a"},
      '{16'd10000, 0  }, '{16'd10000, 0  }, '{16'd10000, 0  }, '{16'd10000, "o"},
      '{16'd0,     0  }, '{16'd1,     0  }, '{16'd2,     0  }, '{16'd3,     "h"},
      '{16'd4501,  0  }, '{16'd18000, 0  }, '{16'd65535, "m"},
      '{16'd0,     0  }, '{16'd0,     0  }, '{16'd5000,  0  }, '{16'd5000,  0  }
   };

   morse_interval_letter_decoder_core uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_interval_ticks (req_interval_ticks),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_letter         (rsp_letter),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic sym_type classify(input logic [INTERVAL_WIDTH-1:0] t);
      if (t > thr.dash && t <= thr.space) return SYM_DASH;
      if (t >= thr.space) return SYM_SPACE;
      return SYM_DOT;
   endfunction

   function automatic logic [LETTER_WIDTH-1:0] code_letter();
      int         len;
      logic [3:0] bits;
      bit         ended;
      byte        ch;
      len   = 0;
      bits  = '0;
      ended = 1'b0;
      for (int i = 0; i < SYMBOLS_PER_LETTER; i++) begin
         if (!ended) begin
            if (sym_buf[i] == SYM_SPACE) begin
               ended = 1'b1;
            end else begin
               bits = {bits[2:0], sym_buf[i] == SYM_DASH};
               len++;
            end
         end
      end
      ch = {1'b0, LETTER_FIRST};
      case (len)
         1: ch = bits[0] ? "t" : "e";
         2: case (bits[1:0])
               2'b00: ch = "i";
               2'b01: ch = "a";
               2'b10: ch = "n";
               2'b11: ch = "m";
               default: ch = {1'b0, LETTER_FIRST};
            endcase
         3: case (bits[2:0])
               3'b000: ch = "s";
               3'b001: ch = "u";
               3'b010: ch = "r";
               3'b011: ch = "w";
               3'b100: ch = "d";
               3'b101: ch = "k";
               3'b110: ch = "g";
               3'b111: ch = "o";
               default: ch = {1'b0, LETTER_FIRST};
            endcase
         4: case (bits)
               4'b0000: ch = "h";
               4'b0001: ch = "v";
               4'b0010: ch = "f";
               4'b0100: ch = "l";
               4'b0110: ch = "p";
               4'b0111: ch = "j";
               4'b1000: ch = "b";
               4'b1001: ch = "x";
               4'b1010: ch = "c";
               4'b1011: ch = "y";
               4'b1100: ch = "z";
               4'b1101: ch = "q";
               // three dashes decode as o whatever follows
               4'b1110, 4'b1111: ch = "o";
               default: ch = {1'b0, LETTER_FIRST};
            endcase
         default: ch = {1'b0, LETTER_FIRST};
      endcase
      return ch[LETTER_WIDTH-1:0];
   endfunction

   function automatic void clear_symbols();
      for (int i = 0; i < SYMBOLS_PER_LETTER; i++) sym_buf[i] = SYM_SPACE;
      sym_count = 0;
   endfunction

   function automatic bit decode_interval(input logic [INTERVAL_WIDTH-1:0] t,
                                          output logic [LETTER_WIDTH-1:0] letter);
      letter = '0;
      if (sym_count < SYMBOLS_PER_LETTER) begin
         sym_buf[sym_count] = classify(t);
         sym_count++;
      end
      if (!(t > thr.gap || sym_count >= SYMBOLS_PER_LETTER)) return 1'b0;
      letter = code_letter();
      clear_symbols();
      return 1'b1;
   endfunction

   function automatic logic [INTERVAL_WIDTH-1:0] pick_ticks(input int lo, input int hi);
      int r;
      if (lo > hi) return INTERVAL_WIDTH'($urandom_range(0, MAX_TICKS));
      r = $urandom_range(0, 7);
      if (r == 0) return INTERVAL_WIDTH'(lo);
      if (r == 1) return INTERVAL_WIDTH'(hi);
      return INTERVAL_WIDTH'($urandom_range(lo, hi));
   endfunction

   // valid is left high on return; the caller either sends again or drops it
   task automatic send_interval(input logic [INTERVAL_WIDTH-1:0] t, input byte typed);
      int                      idle;
      logic [LETTER_WIDTH-1:0] letter;
      idle = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_interval_ticks <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (decode_interval(t, letter))
         letters_due.push_back(typed != 0 ? typed[LETTER_WIDTH-1:0] : letter);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (letters_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // csr_valid is left high on return; the caller drops it after the last write
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [INTERVAL_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_DASH_THRESHOLD:       thr.dash  = data;
         CSR_SPACE_THRESHOLD:      thr.space = data;
         CSR_LETTER_GAP_THRESHOLD: thr.gap   = data;
         default: ;
      endcase
   endtask

   task automatic send_letter();
      int n;
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         send_interval(INTERVAL_WIDTH'($urandom_range(0, MAX_TICKS)), 8'd0);
         return;
      end
      n = $urandom_range(1, SYMBOLS_PER_LETTER);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 1))
            send_interval(pick_ticks(int'(thr.dash) + 1, int'(thr.space)), 8'd0);
         else
            send_interval(pick_ticks(0, int'(thr.dash)), 8'd0);
      end
      if (n < SYMBOLS_PER_LETTER) begin
         if (r < 25)
            send_interval(pick_ticks(int'(thr.space), int'(thr.gap)), 8'd0);
         else
            send_interval(pick_ticks(int'(thr.gap) + 1, MAX_TICKS), 8'd0);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (letters_due.size() == 0) begin
            $error("letter: unexpected %h, nothing expected", rsp_letter);
            mismatches++;
         end else begin
            due_letter = letters_due.pop_front();
            if (rsp_letter !== due_letter) begin
               $error("letter: expected %h actual %h", due_letter, rsp_letter);
               mismatches++;
            end
         end
         rsp_wait = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
         rsp_ready <= (rsp_wait == 0);
         rsp_hold  <= rsp_wait;
      end else if (!rsp_ready) begin
         if (rsp_hold <= 1) rsp_ready <= 1'b1;
         if (rsp_hold > 0) rsp_hold <= rsp_hold - 1;
      end
   end

   initial begin
      int target;
      logic [INTERVAL_WIDTH-1:0] d;
      logic [INTERVAL_WIDTH-1:0] s;
      logic [INTERVAL_WIDTH-1:0] g;
      cycles             = 0;
      mismatches         = 0;
      items_sent         = 0;
      no_idle            = 1'b0;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_interval_ticks <= '0;
      csr_valid          <= 1'b0;
      csr_index          <= '0;
      csr_wdata          <= '0;
      thr.dash  = DASH_THRESHOLD_RESET;
      thr.space = SPACE_THRESHOLD_RESET;
      thr.gap   = LETTER_GAP_THRESHOLD_RESET;
      clear_symbols();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_interval(directed_rows[i].ticks, directed_rows[i].ch);

      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         no_idle = (phase % 4 == 3);
         case (phase)
            0: begin
               d = DASH_THRESHOLD_RESET;
               s = SPACE_THRESHOLD_RESET;
               g = LETTER_GAP_THRESHOLD_RESET;
            end
            1: begin
               d = '0; s = '0; g = '0;
            end
            2: begin
               d = '1; s = '1; g = '1;
            end
            7: begin
               d = INTERVAL_WIDTH'($urandom_range(0, MAX_TICKS));
               s = INTERVAL_WIDTH'($urandom_range(0, MAX_TICKS));
               g = INTERVAL_WIDTH'($urandom_range(0, MAX_TICKS));
            end
            default: begin
               d = INTERVAL_WIDTH'($urandom_range(0, 30000));
               s = INTERVAL_WIDTH'($urandom_range(int'(d), 50000));
               g = INTERVAL_WIDTH'($urandom_range(int'(s), MAX_TICKS));
            end
         endcase
         write_csr(CSR_DASH_THRESHOLD, d);
         write_csr(CSR_SPACE_THRESHOLD, s);
         write_csr(CSR_LETTER_GAP_THRESHOLD, g);
         if (phase % 3 == 1)
            write_csr(2'd3, INTERVAL_WIDTH'($urandom_range(0, MAX_TICKS)));
         csr_valid <= 1'b0;
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) send_letter();
      end

      settle();
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
